[rtl/core/duplicate_read_filter_core_macros.svh]
// assertion macros shared by the duplicate read filter rtl
// expects clk and rst_n in the scope of the module that uses them
`ifndef DUPLICATE_READ_FILTER_CORE_MACROS_SVH
`define DUPLICATE_READ_FILTER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DRF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define DRF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/drf_pkg.sv]
// package of the duplicate read filter: types, codes and default sizes
// no dependencies
package drf_pkg;

    localparam int DEF_TABLE_DEPTH = 4096;
    localparam int DEF_PROBE_LIMIT = 8;
    localparam int DEF_POS_BITS    = 31;

    localparam int CNT_W    = 40;
    localparam int DUPCNT_W = 16;

    localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;

    typedef enum logic [1:0]
    {
        OP_READ         = 2'd0,
        OP_CLEAR_TABLES = 2'd1,
        OP_CLEAR_COUNTS = 2'd2
    } op_t;

    typedef enum logic
    {
        REG_THRESHOLD = 1'b0,
        REG_PAIRED    = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0]
    {
        PR_IDLE,
        PR_CLEAR,
        PR_ISSUE,
        PR_CHECK
    } probe_state_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_CLEAR,
        ST_FINISH
    } top_state_t;

    typedef struct packed
    {
        logic red;
        logic full;
    } probe_res_t;

endpackage

[rtl/core/drf_ram.sv]
// generic simple dual port ram, one write and one registered read port
// no dependencies
module drf_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/drf_hash.sv]
// multiplicative hash of a 64-bit key, three 32x32 partial products
// depends on drf_pkg
module drf_hash
    import drf_pkg::*;
#(
    parameter int AW = 12
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [63:0]   key,
    output logic          done,
    output logic [AW-1:0] hash
);

    logic [63:0] key_reg;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] op_a, op_b;
    logic [63:0] prod;

    // product mod 2^64 = kl*cl + ((kl*ch + kh*cl) << 32)
    always_comb
    begin
        op_a = key_reg[31:0];
        op_b = HASH_MULT[31:0];
        case (step_reg)
            2'd1:
            begin
                op_a = key_reg[31:0];
                op_b = HASH_MULT[63:32];
            end
            2'd2:
            begin
                op_a = key_reg[63:32];
                op_b = HASH_MULT[31:0];
            end
            default:
            begin
                op_a = key_reg[31:0];
                op_b = HASH_MULT[31:0];
            end
        endcase
        prod = 64'(op_a) * 64'(op_b);
    end

    always_comb
    begin
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            if (step_reg == 2'd0)
            begin
                acc_next = prod;
            end
            else
            begin
                acc_next = acc_reg + {prod[31:0], 32'd0};
            end
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd2)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                step_next = 2'd0;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            step_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start && !busy_reg)
        begin
            key_reg <= key;
        end
    end

    assign done = done_reg;
    assign hash = acc_reg[32 +: AW];

endmodule

[rtl/core/drf_probe.sv]
// one key-count table: linear probe, count update, insert and clear sweep
// depends on drf_pkg and drf_ram
module drf_probe
    import drf_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int LIMIT = 8,
    parameter int KW    = 62
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     clear,
    input  logic [KW-1:0]            key,
    input  logic [$clog2(DEPTH)-1:0] hash,
    input  logic [DUPCNT_W-1:0]      threshold,
    output logic                     busy,
    output probe_res_t               res
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = (LIMIT > 1) ? $clog2(LIMIT) : 1;
    localparam int EW = 1 + DUPCNT_W + KW;

    probe_state_t  state_reg, state_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic [PW-1:0] probe_reg, probe_next;
    logic [KW-1:0] key_reg;
    probe_res_t    res_reg, res_next;

    logic                we;
    logic [EW-1:0]       wdata;
    logic [EW-1:0]       rdata;
    logic                rd_valid;
    logic [DUPCNT_W-1:0] rd_cnt;
    logic [KW-1:0]       rd_key;

    // entry layout: valid, count, key
    assign rd_valid = rdata[EW-1];
    assign rd_cnt   = rdata[KW +: DUPCNT_W];
    assign rd_key   = rdata[KW-1:0];

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        probe_next = probe_reg;
        res_next   = res_reg;
        case (state_reg)
            PR_IDLE:
            begin
                if (clear)
                begin
                    state_next = PR_CLEAR;
                    slot_next  = '0;
                end
                else if (start)
                begin
                    state_next = PR_ISSUE;
                    slot_next  = hash;
                    probe_next = '0;
                    res_next   = '0;
                end
            end
            PR_CLEAR:
            begin
                slot_next = slot_reg + AW'(1);
                if (slot_reg == AW'(DEPTH - 1))
                begin
                    state_next = PR_IDLE;
                end
            end
            PR_ISSUE:
            begin
                state_next = PR_CHECK;
            end
            PR_CHECK:
            begin
                if (!rd_valid)
                begin
                    state_next = PR_IDLE;
                end
                else if (rd_key == key_reg)
                begin
                    res_next.red = (rd_cnt >= threshold);
                    state_next   = PR_IDLE;
                end
                else if (probe_reg == PW'(LIMIT - 1))
                begin
                    res_next.full = 1'b1;
                    state_next    = PR_IDLE;
                end
                else
                begin
                    slot_next  = slot_reg + AW'(1);
                    probe_next = probe_reg + PW'(1);
                    state_next = PR_ISSUE;
                end
            end
            default:
            begin
                state_next = PR_IDLE;
            end
        endcase
    end

    always_comb
    begin
        we    = 1'b0;
        wdata = '0;
        case (state_reg)
            PR_CLEAR:
            begin
                we = 1'b1;
            end
            PR_CHECK:
            begin
                if (!rd_valid)
                begin
                    we    = 1'b1;
                    wdata = {1'b1, DUPCNT_W'(1), key_reg};
                end
                else if (rd_key == key_reg && rd_cnt < threshold)
                begin
                    we    = 1'b1;
                    wdata = {1'b1, rd_cnt + DUPCNT_W'(1), key_reg};
                end
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // reset starts a sweep that clears every valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PR_CLEAR;
            slot_reg  <= '0;
            probe_reg <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            probe_reg <= probe_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == PR_IDLE && start && !clear)
        begin
            key_reg <= key;
        end
    end

    drf_ram
    #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    )
    u_ram
    (
        .clk   (clk),
        .we    (we),
        .waddr (slot_reg),
        .wdata (wdata),
        .raddr (slot_reg),
        .rdata (rdata)
    );

    assign busy = (state_reg != PR_IDLE);
    assign res  = res_reg;

endmodule

[rtl/core/duplicate_read_filter_core.sv]
// a read passes through the hash (three partial products), then an issue and a check
// state per probe slot, then finish; a table clear sweeps every slot, other opcodes finish
// one item at a time: the next transfer can be taken in the cycle after the result
// is loaded, so a read also waits out any output stall
// reset clears counters and the paired flag and sets the threshold to 1; a sweep
// then clears both tables while s_tready stays low (configuration writes are still taken)
`include "duplicate_read_filter_core_macros.svh"
module duplicate_read_filter_core
    import drf_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int PROBE_LIMIT = DEF_PROBE_LIMIT,
    parameter int POS_BITS    = DEF_POS_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // pos_first[30:0], pos_mate[61:31], zero pad
    input  logic [2:0]   s_tuser,   // opcode[1:0], sampled[2]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [207:0] m_tdata,   // is_duplicate, table_full, nonred_total, red_total,
                                    // sample_all, sample_nonred, sample_red, zero pad
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int KW = 2 * POS_BITS;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == '1) ? c : c + CNT_W'(1);
    endfunction

    top_state_t          state_reg, state_next;
    logic [1:0]          op_reg;
    logic                sampled_reg;
    logic [KW-1:0]       key_reg;
    logic [DUPCNT_W-1:0] thr_reg;
    logic                paired_reg;

    logic [CNT_W-1:0] nonred_reg, red_reg, sall_reg, snonred_reg, sred_reg;
    logic [CNT_W-1:0] nonred_next, red_next, sall_next, snonred_next, sred_next;
    logic             out_valid_reg;
    logic             dup_reg, tfull_reg;
    logic             dup_next, tfull_next;

    logic                accept, load_out;
    logic [32:0]         first_ext, mate_ext;
    logic [POS_BITS-1:0] pa, pb, lo, hi;
    logic [KW-1:0]       key_in;
    logic                hash_start, hash_done;
    logic [AW-1:0]       hash;
    logic                full_start, samp_start, tab_clear;
    logic                full_busy, samp_busy;
    probe_res_t          full_res, samp_res;

    assign accept = s_tvalid && s_tready;

    // key forming
    assign first_ext = {2'b00, s_tdata[30:0]};
    assign mate_ext  = {2'b00, s_tdata[61:31]};
    assign pa        = first_ext[POS_BITS-1:0];
    assign pb        = mate_ext[POS_BITS-1:0];
    assign lo        = (pa < pb) ? pa : pb;
    assign hi        = (pa < pb) ? pb : pa;
    assign key_in    = paired_reg ? {lo, hi} : {{POS_BITS{1'b0}}, pa};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser[1:0])
                        OP_READ:         state_next = ST_HASH;
                        OP_CLEAR_TABLES: state_next = ST_CLEAR;
                        default:         state_next = ST_FINISH;
                    endcase
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE, ST_CLEAR:
            begin
                if (!full_busy && !samp_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready   = 1'b0;
        hash_start = 1'b0;
        full_start = 1'b0;
        samp_start = 1'b0;
        tab_clear  = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready   = !full_busy && !samp_busy;
                hash_start = accept && (s_tuser[1:0] == OP_READ);
                tab_clear  = accept && (s_tuser[1:0] == OP_CLEAR_TABLES);
            end
            ST_HASH:
            begin
                full_start = hash_done;
                samp_start = hash_done && sampled_reg;
            end
            ST_FINISH:
            begin
                load_out = !out_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // counter update for the finished item
    always_comb
    begin
        nonred_next  = nonred_reg;
        red_next     = red_reg;
        sall_next    = sall_reg;
        snonred_next = snonred_reg;
        sred_next    = sred_reg;
        dup_next     = 1'b0;
        tfull_next   = 1'b0;
        case (op_reg)
            OP_READ:
            begin
                dup_next   = full_res.red;
                tfull_next = full_res.full || (sampled_reg && samp_res.full);
                if (full_res.red)
                begin
                    red_next = sat_inc(red_reg);
                end
                else
                begin
                    nonred_next = sat_inc(nonred_reg);
                end
                if (sampled_reg)
                begin
                    sall_next = sat_inc(sall_reg);
                    if (samp_res.red)
                    begin
                        sred_next = sat_inc(sred_reg);
                    end
                    else
                    begin
                        snonred_next = sat_inc(snonred_reg);
                    end
                end
            end
            OP_CLEAR_COUNTS:
            begin
                nonred_next  = '0;
                red_next     = '0;
                sall_next    = '0;
                snonred_next = '0;
                sred_next    = '0;
            end
            default:
            begin
                dup_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            nonred_reg    <= '0;
            red_reg       <= '0;
            sall_reg      <= '0;
            snonred_reg   <= '0;
            sred_reg      <= '0;
            thr_reg       <= DUPCNT_W'(1);
            paired_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                nonred_reg    <= nonred_next;
                red_reg       <= red_next;
                sall_reg      <= sall_next;
                snonred_reg   <= snonred_next;
                sred_reg      <= sred_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (psel && penable && pwrite)
            begin
                case (reg_idx_t'(paddr[2]))
                    REG_THRESHOLD: thr_reg    <= pwdata[DUPCNT_W-1:0];
                    REG_PAIRED:    paired_reg <= pwdata[0];
                    default:       paired_reg <= paired_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= s_tuser[1:0];
            sampled_reg <= s_tuser[2];
            key_reg     <= key_in;
        end
        if (load_out)
        begin
            dup_reg   <= dup_next;
            tfull_reg <= tfull_next;
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[2]))
            REG_THRESHOLD: prdata = {16'd0, thr_reg};
            REG_PAIRED:    prdata = {31'd0, paired_reg};
            default:       prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, sred_reg, snonred_reg, sall_reg, red_reg, nonred_reg,
                       tfull_reg, dup_reg};

    drf_hash
    #(
        .AW (AW)
    )
    u_hash
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (64'(key_in)),
        .done  (hash_done),
        .hash  (hash)
    );

    drf_probe
    #(
        .DEPTH (TABLE_DEPTH),
        .LIMIT (PROBE_LIMIT),
        .KW    (KW)
    )
    u_full
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (full_start),
        .clear     (tab_clear),
        .key       (key_reg),
        .hash      (hash),
        .threshold (thr_reg),
        .busy      (full_busy),
        .res       (full_res)
    );

    drf_probe
    #(
        .DEPTH (TABLE_DEPTH),
        .LIMIT (PROBE_LIMIT),
        .KW    (KW)
    )
    u_samp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (samp_start),
        .clear     (tab_clear),
        .key       (key_reg),
        .hash      (hash),
        .threshold (thr_reg),
        .busy      (samp_busy),
        .res       (samp_res)
    );

    `DRF_ASSERT_SAME(a_no_accept_busy, accept, !full_busy && !samp_busy, "item taken during table work")
    `DRF_ASSERT_NEXT(a_load_only_finish, load_out, m_tvalid, "result load lost")
    `DRF_ASSERT_SAME(a_red_monotonic, red_reg < $past(red_reg), $past(load_out) && $past(op_reg) == OP_CLEAR_COUNTS, "red count dropped without clear")

endmodule

[dv/tb.sv]
// self-checking testbench for duplicate_read_filter_core: stream reads in, compare each result
// against a behavioral table/counter predictor; depends on drf_pkg and the core rtl
module tb;
    import drf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEF_TABLE_DEPTH;
    localparam int PROBES = DEF_PROBE_LIMIT;
    localparam int PB = DEF_POS_BITS;
    localparam logic [39:0] CMAX = 40'hFF_FFFF_FFFF;
    localparam longint LIMIT = 3000000;

    typedef struct packed
    {
        logic [39:0] s_red;
        logic [39:0] s_nonred;
        logic [39:0] s_all;
        logic [39:0] red;
        logic [39:0] nonred;
        logic        full;
        logic        dup;
    } verdict_t;

    logic clk, rst_n;
    logic s_tvalid, s_tready, m_tvalid, m_tready;
    logic [63:0] s_tdata;
    logic [2:0] s_tuser;
    logic [207:0] m_tdata;
    logic psel, penable, pwrite, pready;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;

    duplicate_read_filter_core uut (.*);

    // predictor state
    logic [61:0] fk [DEPTH], sk [DEPTH];
    logic [15:0] fc [DEPTH], sc [DEPTH];
    bit fv [DEPTH], sv [DEPTH];
    logic [15:0] thresh;
    bit paired;
    logic [39:0] c_nonred, c_red, c_sall, c_snon, c_sred;
    verdict_t expected_q [$];
    int errors, n_results, n_dups, n_full;
    longint cycles;
    int hold_off;
    int rx_wait;

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("duplicate_read_filter_core regression: fail");
            $finish;
        end
    end

    function automatic logic [39:0] sat(logic [39:0] c);
        return (c == CMAX) ? c : c + 1;
    endfunction

    // returns redundant flag; sets full when no slot was free
    function automatic bit probe_table(bit is_sample, logic [61:0] key, output bit full);
        logic [63:0] prod;
        int h, s;
        prod = {2'b0, key} * 64'h9E3779B97F4A7C15;
        h = int'(prod[63:32] % DEPTH);
        full = 0;
        for (int i = 0; i < PROBES; i++)
        begin
            s = (h + i) % DEPTH;
            if (!(is_sample ? sv[s] : fv[s]))
            begin
                if (is_sample) begin sv[s] = 1; sk[s] = key; sc[s] = 1; end
                else begin fv[s] = 1; fk[s] = key; fc[s] = 1; end
                return 0;
            end
            if ((is_sample ? sk[s] : fk[s]) == key)
            begin
                if ((is_sample ? sc[s] : fc[s]) < thresh)
                begin
                    if (is_sample) sc[s] = sc[s] + 1;
                    else fc[s] = fc[s] + 1;
                    return 0;
                end
                return 1;
            end
        end
        full = 1;
        return 0;
    endfunction

    function automatic verdict_t classify_read(logic [1:0] op, logic [30:0] a, logic [30:0] b,
                                               bit samp);
        verdict_t v;
        logic [61:0] key;
        bit f1, f2;
        v = '0;
        f1 = 0;
        f2 = 0;
        if (op == OP_READ)
        begin
            key = paired ? ((a < b) ? {a, b} : {b, a}) : {31'b0, a};
            if (probe_table(0, key, f1))
            begin
                v.dup = 1;
                c_red = sat(c_red);
            end
            else
                c_nonred = sat(c_nonred);
            if (samp)
            begin
                c_sall = sat(c_sall);
                if (probe_table(1, key, f2)) c_sred = sat(c_sred);
                else c_snon = sat(c_snon);
            end
            v.full = f1 | f2;
        end
        else if (op == OP_CLEAR_TABLES)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                fv[i] = 0;
                sv[i] = 0;
            end
        end
        else if (op == OP_CLEAR_COUNTS)
        begin
            c_nonred = 0; c_red = 0; c_sall = 0; c_snon = 0; c_sred = 0;
        end
        v.nonred = c_nonred;
        v.red = c_red;
        v.s_all = c_sall;
        v.s_nonred = c_snon;
        v.s_red = c_sred;
        return v;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        verdict_t g, e;
        if (rst_n && m_tvalid && m_tready)
        begin
            g = verdict_t'(m_tdata[201:0]);
            n_results++;
            if (expected_q.size() == 0)
                report("unexpected result", m_tdata[63:0], 0);
            else
            begin
                e = expected_q.pop_front();
                if (g.dup) n_dups++;
                if (g.full) n_full++;
                if (g.dup !== e.dup) report("is_duplicate", g.dup, e.dup);
                if (g.full !== e.full) report("table_full", g.full, e.full);
                if (g.nonred !== e.nonred) report("nonred_total", g.nonred, e.nonred);
                if (g.red !== e.red) report("red_total", g.red, e.red);
                if (g.s_all !== e.s_all) report("sample_all", g.s_all, e.s_all);
                if (g.s_nonred !== e.s_nonred) report("sample_nonred", g.s_nonred, e.s_nonred);
                if (g.s_red !== e.s_red) report("sample_red", g.s_red, e.s_red);
            end
        end
    end

    // receiver: a drawn wait after each result, or a long hold-off when requested
    always @(posedge clk)
    begin
        int w;
        if (!rst_n)
        begin
            m_tready <= 0;
            rx_wait <= 0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
            rx_wait <= w;
            m_tready <= (w == 0);
        end
        else if (!m_tready)
        begin
            if (rx_wait > 1)
                rx_wait <= rx_wait - 1;
            else
            begin
                rx_wait <= 0;
                m_tready <= 1;
            end
        end
    end

    // valid stays high after a transfer until the next item or a drain takes it down
    task automatic send_item(logic [1:0] op, logic [30:0] a, logic [30:0] b, bit samp,
                             bit gaps = 1);
        int w;
        w = gaps ? (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16)) : 0;
        if (w > 0)
        begin
            s_tvalid <= 0;
            repeat (w) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {2'b0, b, a};
        s_tuser <= {samp, op};
        expected_q.push_back(classify_read(op, a, b, samp));
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (2 * PROBES + 10) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        drain();
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= 3'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (idx == REG_THRESHOLD) thresh = val[15:0];
        else paired = val[0];
    endtask

    function automatic logic [30:0] rpos();
        case ($urandom_range(0, 3))
            0: return 31'($urandom_range(0, 40));
            1: return 31'h7FFF_FFFF - 31'($urandom_range(0, 40));
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        write_reg(REG_THRESHOLD, 2);
        send_item(OP_READ, 0, 0, 1);
        send_item(OP_READ, 0, 0, 1);
        send_item(OP_READ, 0, 0, 1);
        send_item(OP_READ, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
        send_item(3, 5, 6, 1);
        write_reg(REG_PAIRED, 1);
        send_item(OP_READ, 31'h7FFF_FFFF, 0, 1);
        send_item(OP_READ, 0, 31'h7FFF_FFFF, 1);
        send_item(OP_READ, 0, 31'h7FFF_FFFF, 1);
        send_item(OP_READ, 31'h5555_5555, 31'h2AAA_AAAA, 0);
        write_reg(REG_THRESHOLD, 0);
        send_item(OP_READ, 0, 31'h7FFF_FFFF, 1);
        send_item(OP_CLEAR_COUNTS, 0, 0, 0);
        send_item(OP_CLEAR_TABLES, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1);
        send_item(OP_READ, 0, 31'h7FFF_FFFF, 1);
    endtask

    // many distinct keys to overflow the probe window
    task automatic test_table_full();
        write_reg(REG_PAIRED, 0);
        write_reg(REG_THRESHOLD, 1);
        for (int i = 0; i < 400; i++)
            send_item(OP_READ, 31'($urandom), 0, $urandom_range(0, 1), i < 40);
        for (int i = 0; i < 40; i++)
            send_item(OP_READ, 31'($urandom_range(0, 8)), 0, 1);
        send_item(OP_CLEAR_TABLES, 0, 0, 0);
    endtask

    task automatic test_random(int n, bit pair, logic [15:0] th);
        logic [30:0] pool [16];
        logic [1:0] op;
        write_reg(REG_PAIRED, pair);
        write_reg(REG_THRESHOLD, th);
        foreach (pool[i]) pool[i] = rpos();
        for (int i = 0; i < n; i++)
        begin
            op = ($urandom_range(0, 60) == 0) ? 2'($urandom_range(1, 3)) : OP_READ;
            if ($urandom_range(0, 3) == 0)
                send_item(op, rpos(), rpos(), $urandom_range(0, 1));
            else
                send_item(op, pool[$urandom_range(0, 15)], pool[$urandom_range(0, 3)],
                          $urandom_range(0, 1));
        end
    endtask

    // receiver stalls long while the sender keeps offering
    task automatic test_backpressure();
        drain();
        hold_off = 300;
        for (int i = 0; i < 30; i++)
            send_item(OP_READ, 31'($urandom_range(0, 20)), 0, 1, 0);
        drain();
    endtask

    initial
    begin
        rst_n = 0;
        s_tvalid = 0; s_tdata = 0; s_tuser = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        errors = 0; n_results = 0; n_dups = 0; n_full = 0; cycles = 0; hold_off = 0;
        thresh = 1; paired = 0;
        c_nonred = 0; c_red = 0; c_sall = 0; c_snon = 0; c_sred = 0;
        foreach (fv[i]) begin fv[i] = 0; sv[i] = 0; end
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_table_full();
        test_backpressure();
        test_random(400, 0, 1);
        test_random(400, 1, 3);
        test_random(300, 0, 16'hFFFF);
        test_random(150, 1, 0);
        drain();
        $display("covered %0d results: %0d duplicates, %0d table-full, single and paired keys,",
                 n_results, n_dups, n_full);
        $display("thresholds 0 to 65535, clears, unused opcode and long output stalls");
        if (errors == 0)
            $display("duplicate_read_filter_core regression: pass");
        else
            $display("duplicate_read_filter_core regression: fail");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/drf_pkg.sv
rtl/core/drf_ram.sv
rtl/core/drf_hash.sv
rtl/core/drf_probe.sv
rtl/core/duplicate_read_filter_core.sv
dv/tb.sv
